>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, switched off while reset is high.
`define POC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pattern counter check failed");

// Property checked at every rising clock edge, reset cycles included.
`define POC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pattern counter check failed");

`endif

>>> rtl/poc_pkg.sv
// Shared types and constants of the pattern occurrence counter.
`default_nettype none

package poc_pkg;

   // Fixed field widths.
   localparam int ByteBits     = 8;
   localparam int LengthBits   = 5;
   localparam int FieldBits    = 32;
   localparam int CsrDataBits  = 64;
   localparam int CsrIndexBits = 2;

   // Pattern bytes that the configuration registers can hold.
   localparam int PatternRegBytes = 20;

   typedef logic [CsrIndexBits-1:0] csr_index_type;
   typedef logic [ByteBits-1:0]     byte_type;

   // Configuration register indexes.
   localparam csr_index_type CsrPatternLength = 2'd0;
   localparam csr_index_type CsrPatternLow    = 2'd1;
   localparam csr_index_type CsrPatternMid    = 2'd2;
   localparam csr_index_type CsrPatternHigh   = 2'd3;

endpackage

`default_nettype wire

>>> rtl/pattern_occurrence_counter_top.sv
// Top level of the pattern occurrence counter: byte window, pattern compare and counters.
//
// The block counts every occurrence, overlapping ones included, of a configured
// pattern of up to MAX_PATTERN bytes in a byte stream, and counts the stream's
// length. It takes one byte per clock cycle while no end-of-stream byte waits. An
// accepted byte lands in an input register and is compared against the pattern from
// there, together with the window of the last MAX_PATTERN-1 bytes. For the byte
// flagged as the end of the stream, the result is written to the output register in
// the cycle in which that byte is compared. The window shift register and both
// counters are updated once per byte, which sets the rate of one byte per cycle. The
// input register keeps taking bytes while a result waits to be taken; only a second
// end-of-stream byte waits for the output register to drain. Both counters saturate
// at 2^COUNT_BITS - 1 and the outputs carry their low 32 bits. After the
// end-of-stream byte the stream state clears; the pattern configuration is kept.
// A pattern length of zero never matches, and a length above MAX_PATTERN acts as
// MAX_PATTERN.
`default_nettype none

module pattern_occurrence_counter_top #(
   parameter int MAX_PATTERN = 20,
   parameter int COUNT_BITS  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input byte channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [poc_pkg::ByteBits-1:0]        req_data_byte,
   input  wire logic                                req_end_of_stream,
   // Result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [poc_pkg::FieldBits-1:0]            rsp_stream_length,
   output logic [poc_pkg::FieldBits-1:0]            rsp_match_total,
   // Configuration write port
   input  wire logic                                csr_write_en,
   input  wire poc_pkg::csr_index_type              csr_index,
   input  wire logic [poc_pkg::CsrDataBits-1:0]     csr_data
);

   localparam int WinDepth = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam int FillBits = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int IdxBits  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LenBits  = ($clog2(MAX_PATTERN + 1) > poc_pkg::LengthBits) ?
                             $clog2(MAX_PATTERN + 1) : poc_pkg::LengthBits;
   localparam int ExtBits  = (COUNT_BITS > poc_pkg::FieldBits) ?
                             COUNT_BITS : poc_pkg::FieldBits;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;
   localparam logic [FillBits-1:0]   FillMax  = FillBits'(MAX_PATTERN - 1);

   // Configuration registers.
   logic [poc_pkg::LengthBits-1:0] pattern_length_ff;
   poc_pkg::byte_type              pattern_byte [MAX_PATTERN];

   // Input register.
   logic              in_valid_ff, in_valid_in;
   poc_pkg::byte_type in_byte_ff;
   logic              in_last_ff;

   // Stream state.
   poc_pkg::byte_type       window_ff [WinDepth];
   logic [FillBits-1:0]     fill_ff, fill_in;
   logic [COUNT_BITS-1:0]   byte_count_ff, byte_count_in;
   logic [COUNT_BITS-1:0]   match_count_ff, match_count_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [poc_pkg::FieldBits-1:0]  rsp_length_ff, rsp_total_ff;

   logic                     out_free;
   logic                     process;
   logic [LenBits-1:0]       eff_len;
   logic [MAX_PATTERN-1:0]   byte_ok;
   logic                     hit;
   logic [COUNT_BITS-1:0]    byte_next, match_next;
   logic [ExtBits-1:0]       byte_next_ext, match_next_ext;

   // Pattern length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= poc_pkg::LengthBits'(1);
      end else if (csr_write_en && csr_index == poc_pkg::CsrPatternLength) begin
         pattern_length_ff <= csr_data[poc_pkg::LengthBits-1:0];
      end
   end

   // Pattern byte registers; bytes past the register set read as zero.
   for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pattern
      if (p < poc_pkg::PatternRegBytes) begin : g_stored
         localparam poc_pkg::csr_index_type Code =
            (p < 8) ? poc_pkg::CsrPatternLow :
            (p < 16) ? poc_pkg::CsrPatternMid : poc_pkg::CsrPatternHigh;
         localparam int Offset = (p % 8) * poc_pkg::ByteBits;
         poc_pkg::byte_type byte_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               byte_ff <= '0;
            end else if (csr_write_en && csr_index == Code) begin
               byte_ff <= csr_data[Offset +: poc_pkg::ByteBits];
            end
         end
         assign pattern_byte[p] = byte_ff;
      end else begin : g_zero
         assign pattern_byte[p] = '0;
      end
   end

   // Flow control: an end-of-stream byte needs a free output register.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !process;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_end_of_stream;
      end
   end

   // Effective pattern length, limited to the window size.
   always_comb begin
      if (LenBits'(pattern_length_ff) > LenBits'(MAX_PATTERN)) begin
         eff_len = LenBits'(MAX_PATTERN);
      end else begin
         eff_len = LenBits'(pattern_length_ff);
      end
   end

   // Compare each candidate byte with the pattern byte that lines up with it.
   // Candidate 0 is the current byte, candidate k the byte k places earlier.
   always_comb begin
      logic [LenBits-1:0] idx;
      poc_pkg::byte_type  cand;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         idx  = eff_len - LenBits'(1) - LenBits'(k);
         cand = (k == 0) ? in_byte_ff : window_ff[(k == 0) ? 0 : k - 1];
         if (LenBits'(k) < eff_len) begin
            byte_ok[k] = (pattern_byte[idx[IdxBits-1:0]] == cand);
         end else begin
            byte_ok[k] = 1'b1;
         end
      end
   end

   // A match needs a nonzero length and enough bytes seen in this stream.
   assign hit = (eff_len != '0) &&
                (LenBits'(fill_ff) + LenBits'(1) >= eff_len) && (&byte_ok);

   // Saturating counter updates.
   assign byte_next  = (byte_count_ff == CountMax) ? byte_count_ff
                                                   : byte_count_ff + 1'b1;
   assign match_next = (hit && match_count_ff != CountMax) ? match_count_ff + 1'b1
                                                           : match_count_ff;
   assign byte_next_ext  = ExtBits'(byte_next);
   assign match_next_ext = ExtBits'(match_next);

   // Stream state next values; the end-of-stream byte starts a new stream.
   always_comb begin
      fill_in        = fill_ff;
      byte_count_in  = byte_count_ff;
      match_count_in = match_count_ff;
      if (process) begin
         if (in_last_ff) begin
            fill_in        = '0;
            byte_count_in  = '0;
            match_count_in = '0;
         end else begin
            fill_in        = (fill_ff == FillMax) ? fill_ff : fill_ff + 1'b1;
            byte_count_in  = byte_next;
            match_count_in = match_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         byte_count_ff  <= '0;
         match_count_ff <= '0;
      end else begin
         fill_ff        <= fill_in;
         byte_count_ff  <= byte_count_in;
         match_count_ff <= match_count_in;
      end
   end

   // Byte window shift register; entries are read only once filled.
   always_ff @(posedge clock) begin
      if (process) begin
         window_ff[0] <= in_byte_ff;
         for (int k = 1; k < WinDepth; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && in_last_ff) begin
         rsp_length_ff <= byte_next_ext[poc_pkg::FieldBits-1:0];
         rsp_total_ff  <= match_next_ext[poc_pkg::FieldBits-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stream_length = rsp_length_ff;
   assign rsp_match_total   = rsp_total_ff;

endmodule

`default_nettype wire

>>> rtl/poc_checker.sv
// Port-level checks of the pattern occurrence counter and their binding.
`default_nettype none

`include "assert_macros.svh"

module poc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [poc_pkg::FieldBits-1:0]     rsp_stream_length,
   input wire logic [poc_pkg::FieldBits-1:0]     rsp_match_total
);

   // A stalled result transaction keeps its valid and its payload.
   `POC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stream_length) && $stable(rsp_match_total))

   // Input stalls only while a finished result is held back downstream.
   `POC_ASSERT_ALWAYS(a_stall_cause, clock, req_stall |-> rsp_valid && rsp_stall)

   // Reset leaves no result pending.
   `POC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // An idle input channel never sees a stall without a pending result.
   `POC_ASSERT(a_idle_stall, clock, reset, !req_valid && !rsp_valid |-> !req_stall)

endmodule

bind pattern_occurrence_counter_top poc_checker u_poc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_stream_length (rsp_stream_length),
   .rsp_match_total   (rsp_match_total)
);

`default_nettype wire
